// File: rtl/core/rgbled_pkg.sv
package rgbled_pkg;

   // Field widths fixed by the item and register formats.
   localparam int PHASE_W = 12;
   localparam int TIMER_W = 16;
   localparam int MODE_W  = 3;
   localparam int DUTY_W  = 8;
   localparam int CSR_IDX_W = 2;
   localparam int SUB_W   = 7;

   // Request kinds carried on the input word's tuser.
   typedef enum logic [1:0] {
      REQ_TICK   = 2'd0,
      REQ_MODE   = 2'd1,
      REQ_PULSE  = 2'd2,
      REQ_STROBE = 2'd3
   } req_kind_type;

   // Status modes.
   localparam logic [MODE_W-1:0] MODE_OFF        = 3'd0;
   localparam logic [MODE_W-1:0] MODE_BOOT_HW    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_BOOT_WIFI  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_BOOT_SYNC  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_BOOT_READY = 3'd4;
   localparam logic [MODE_W-1:0] MODE_WIFI_LOST  = 3'd5;
   localparam logic [MODE_W-1:0] MODE_FAULT      = 3'd6;
   localparam logic [MODE_W-1:0] MODE_UNUSED     = 3'd7;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_STROBE_DUR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_DUR  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_READY_HOLD = 2'd2;

   // Register reset values.
   localparam logic [TIMER_W-1:0] STROBE_DUR_RST = 16'd3000;
   localparam logic [TIMER_W-1:0] PULSE_DUR_RST  = 16'd30;
   localparam logic [TIMER_W-1:0] READY_HOLD_RST = 16'd1000;

   // Blink timing in milliseconds.
   localparam logic [SUB_W-1:0]   STROBE_HALF  = 7'd125;
   localparam logic [SUB_W-1:0]   FAULT_HALF   = 7'd100;
   localparam logic [PHASE_W-1:0] FAULT_WINDOW = 12'd600;

   // Colour intensities.
   localparam logic [DUTY_W-1:0] I_WHITE      = 8'd120;
   localparam logic [DUTY_W-1:0] I_PURPLE     = 8'd150;
   localparam logic [DUTY_W-1:0] I_PULSE_G    = 8'd40;
   localparam logic [DUTY_W-1:0] I_PULSE_B    = 8'd60;
   localparam logic [DUTY_W-1:0] I_HW_R       = 8'd180;
   localparam logic [DUTY_W-1:0] I_HW_G       = 8'd45;
   localparam logic [DUTY_W-1:0] I_WIFI_B     = 8'd150;
   localparam logic [DUTY_W-1:0] I_READY_G    = 8'd25;
   localparam logic [DUTY_W-1:0] I_FAULT_R    = 8'd200;
   localparam logic [DUTY_W-1:0] I_DARK       = 8'd0;

   // Configuration registers as seen by the engine.
   typedef struct packed {
      logic [TIMER_W-1:0] strobe_dur;
      logic [TIMER_W-1:0] pulse_dur;
      logic [TIMER_W-1:0] ready_hold;
   } cfg_type;

   // One input item.
   typedef struct packed {
      req_kind_type      req_type;
      logic [MODE_W-1:0] new_mode;
      logic              display_sleeping;
   } item_type;

   // One result item.
   typedef struct packed {
      logic [DUTY_W-1:0] drive_red;
      logic [DUTY_W-1:0] drive_green;
      logic [DUTY_W-1:0] drive_blue;
      logic [MODE_W-1:0] mode_now;
   } result_type;

   // Active-low duty from an intensity.
   function automatic logic [DUTY_W-1:0] duty(input logic [DUTY_W-1:0] level);
      duty = ~level;
   endfunction

endpackage

// File: rtl/core/rgbled_csr.sv
module rgbled_csr
   import rgbled_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TIMER_W-1:0]   csr_data,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write; an index with no register is dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_STROBE_DUR: cfg_in.strobe_dur = csr_data;
            CSR_PULSE_DUR:  cfg_in.pulse_dur  = csr_data;
            CSR_READY_HOLD: cfg_in.ready_hold = csr_data;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.strobe_dur <= STROBE_DUR_RST;
         cfg_ff.pulse_dur  <= PULSE_DUR_RST;
         cfg_ff.ready_hold <= READY_HOLD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/core/rgbled_engine.sv
module rgbled_engine
   import rgbled_pkg::*;
#(
   parameter int PHASE_PERIOD = 3000
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       step,
   input  item_type   item,
   output result_type result
);

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [SUB_W-1:0]   sub125_ff, sub125_in;
   logic               par125_ff, par125_in;
   logic [SUB_W-1:0]   sub100_ff, sub100_in;
   logic               par100_ff, par100_in;
   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic               strobe_on_ff, strobe_on_in;
   logic [TIMER_W-1:0] strobe_el_ff, strobe_el_in;
   logic               pulse_on_ff, pulse_on_in;
   logic [TIMER_W-1:0] pulse_el_ff, pulse_el_in;
   logic [TIMER_W-1:0] ready_el_ff, ready_el_in;

   logic [PHASE_W:0]   phase_inc;
   logic [TIMER_W:0]   ready_inc;
   logic               fault_lit;

   assign phase_inc = {1'b0, phase_ff} + {{PHASE_W{1'b0}}, 1'b1};
   assign ready_inc = {1'b0, ready_el_ff} + {{TIMER_W{1'b0}}, 1'b1};

   // Next state for the accepted item. The sub-counters follow the phase so
   // that the blink parities need no division.
   always_comb begin
      phase_in     = phase_ff;
      sub125_in    = sub125_ff;
      par125_in    = par125_ff;
      sub100_in    = sub100_ff;
      par100_in    = par100_ff;
      mode_in      = mode_ff;
      strobe_on_in = strobe_on_ff;
      strobe_el_in = strobe_el_ff;
      pulse_on_in  = pulse_on_ff;
      pulse_el_in  = pulse_el_ff;
      ready_el_in  = ready_el_ff;
      case (item.req_type)
         REQ_TICK: begin
            if (phase_inc >= (PHASE_W + 1)'(PHASE_PERIOD)) begin
               phase_in  = '0;
               sub125_in = '0;
               par125_in = 1'b0;
               sub100_in = '0;
               par100_in = 1'b0;
            end else begin
               phase_in = phase_inc[PHASE_W-1:0];
               if (sub125_ff == STROBE_HALF - 7'd1) begin
                  sub125_in = '0;
                  par125_in = ~par125_ff;
               end else begin
                  sub125_in = sub125_ff + 7'd1;
               end
               if (sub100_ff == FAULT_HALF - 7'd1) begin
                  sub100_in = '0;
                  par100_in = ~par100_ff;
               end else begin
                  sub100_in = sub100_ff + 7'd1;
               end
            end
            if (strobe_on_ff) begin
               if (strobe_el_ff >= cfg.strobe_dur) begin
                  strobe_on_in = 1'b0;
               end else begin
                  strobe_el_in = strobe_el_ff + 16'd1;
               end
            end
            if (pulse_on_ff) begin
               if (pulse_el_ff >= cfg.pulse_dur) begin
                  pulse_on_in = 1'b0;
               end else begin
                  pulse_el_in = pulse_el_ff + 16'd1;
               end
            end
            if (mode_ff == MODE_BOOT_READY) begin
               if (ready_inc >= {1'b0, cfg.ready_hold}) begin
                  mode_in     = MODE_OFF;
                  ready_el_in = '0;
               end else begin
                  ready_el_in = ready_inc[TIMER_W-1:0];
               end
            end
         end
         REQ_MODE: begin
            mode_in     = (item.new_mode == MODE_UNUSED) ? MODE_OFF : item.new_mode;
            ready_el_in = '0;
         end
         REQ_PULSE: begin
            if (!item.display_sleeping) begin
               pulse_on_in = 1'b1;
               pulse_el_in = '0;
            end
         end
         default: begin
            strobe_on_in = 1'b1;
            strobe_el_in = '0;
         end
      endcase
   end

   assign fault_lit = (phase_in < FAULT_WINDOW) && !par100_in;

   // Colour selection in priority order: strobe, pulse, mode.
   always_comb begin
      result.mode_now    = mode_in;
      result.drive_red   = duty(I_DARK);
      result.drive_green = duty(I_DARK);
      result.drive_blue  = duty(I_DARK);
      if (strobe_on_in) begin
         if (!par125_in) begin
            result.drive_red   = duty(I_WHITE);
            result.drive_green = duty(I_WHITE);
            result.drive_blue  = duty(I_WHITE);
         end else begin
            result.drive_red   = duty(I_PURPLE);
            result.drive_blue  = duty(I_PURPLE);
         end
      end else if (pulse_on_in) begin
         result.drive_green = duty(I_PULSE_G);
         result.drive_blue  = duty(I_PULSE_B);
      end else begin
         case (mode_in)
            MODE_BOOT_HW: begin
               result.drive_red   = duty(I_HW_R);
               result.drive_green = duty(I_HW_G);
            end
            MODE_BOOT_WIFI:  result.drive_blue  = duty(I_WIFI_B);
            MODE_BOOT_READY: result.drive_green = duty(I_READY_G);
            MODE_FAULT: begin
               if (fault_lit) begin
                  result.drive_red = duty(I_FAULT_R);
               end
            end
            default: result.drive_red = duty(I_DARK);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         sub125_ff    <= '0;
         par125_ff    <= 1'b0;
         sub100_ff    <= '0;
         par100_ff    <= 1'b0;
         mode_ff      <= MODE_OFF;
         strobe_on_ff <= 1'b0;
         strobe_el_ff <= '0;
         pulse_on_ff  <= 1'b0;
         pulse_el_ff  <= '0;
         ready_el_ff  <= '0;
      end else if (step) begin
         phase_ff     <= phase_in;
         sub125_ff    <= sub125_in;
         par125_ff    <= par125_in;
         sub100_ff    <= sub100_in;
         par100_ff    <= par100_in;
         mode_ff      <= mode_in;
         strobe_on_ff <= strobe_on_in;
         strobe_el_ff <= strobe_el_in;
         pulse_on_ff  <= pulse_on_in;
         pulse_el_ff  <= pulse_el_in;
         ready_el_ff  <= ready_el_in;
      end
   end

   // The phase stays inside its period and the sub-counters inside theirs.
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff < PHASE_W'(PHASE_PERIOD))
      else $error("phase counter left its period");

   a_sub_range: assert property (@(posedge clock) disable iff (reset)
      (sub125_ff < STROBE_HALF) && (sub100_ff < FAULT_HALF))
      else $error("blink sub-counter out of range");

   // A phase at zero means both sub-counters and both blink parities are cleared.
   a_sub_zero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == '0) |-> (sub125_ff == '0 && sub100_ff == '0 && !par125_ff && !par100_ff))
      else $error("sub-counters not aligned with phase wrap");

   // The unused mode code is never stored.
   a_mode_code: assert property (@(posedge clock) disable iff (reset)
      mode_ff != MODE_UNUSED)
      else $error("unused mode code stored");

   // Mode and phase hold in every cycle that takes no item.
   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(mode_ff) && $stable(phase_ff))
      else $error("state changed without an item");

endmodule

// File: rtl/core/rgb_status_led_pattern_engine.sv
// Status LED pattern engine: each input word (a 1 ms tick, a mode write, a
// traffic-pulse trigger or a priority-strobe trigger) yields exactly one
// result word with the active-low red, green and blue duties and the current
// mode. The block takes one word per clock cycle unless the input register
// is full and the result register stalled; the two registers frame a single
// combinational pass that updates the phase, timers and mode and selects
// the colour. Configuration writes are registered and should only be
// issued while no word is in flight. PHASE_PERIOD sets the length of the
// free-running phase in ticks (250 to 4095).
module rgb_status_led_pattern_engine
   import rgbled_pkg::*;
#(
   parameter int PHASE_PERIOD = 3000
) (
   input  logic                 clock,
   input  logic                 reset,
   // Input words.
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // new_mode[2:0], display_sleeping[3], zero pad
   input  logic [1:0]           req_tuser,   // req_type[1:0]
   // Result words.
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata,   // drive_red[7:0], drive_green[15:8],
                                             // drive_blue[23:16], mode_now[26:24], zero pad
   // Configuration writes.
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TIMER_W-1:0]   csr_data
);

   cfg_type    cfg;
   item_type   item_ff, item_in;
   logic       req_valid_ff, req_valid_in;
   result_type result;
   result_type result_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;
   logic       step;
   logic       req_take;

   assign csr_ready = 1'b1;

   rgbled_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Stage handshake: the input register moves on whenever the result
   // register is empty or being drained.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign step       = req_valid_ff && out_free;
   assign req_tready = !req_valid_ff || out_free;
   assign req_take   = req_tvalid && req_tready;

   assign req_valid_in = req_take || (req_valid_ff && !step);
   assign rsp_valid_in = step || (rsp_valid_ff && !rsp_tready);

   assign item_in.req_type         = req_kind_type'(req_tuser[1:0]);
   assign item_in.new_mode         = req_tdata[2:0];
   assign item_in.display_sleeping = req_tdata[3];

   rgbled_engine #(
      .PHASE_PERIOD (PHASE_PERIOD)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .step   (step),
      .item   (item_ff),
      .result (result)
   );

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
      if (step) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, result_ff.mode_now, result_ff.drive_blue,
                        result_ff.drive_green, result_ff.drive_red};

   // A word in the input register is consumed only when the result slot frees.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !step)
      else $error("result register overwritten while stalled");

   // Every step produces a result word on the next cycle.
   a_step_result: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("step without result");

   // Input register full and blocked means no new word is taken.
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && !out_free) |-> !req_tready)
      else $error("input register accepted while full");

endmodule
